// ----- rtl/core/yuyv_to_rgb_converter_macros.svh -----
// assertion macros for the yuyv to rgb converter checker
`ifndef YUYV_TO_RGB_CONVERTER_MACROS_SVH
`define YUYV_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication, reset masks the check
`define Y2R_ASSERT_NOW(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("y2r check failed");

// next-cycle implication, reset masks the check
`define Y2R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("y2r check failed");

`endif

// ----- rtl/core/y2r_pkg.sv -----
// shared widths, register codes and helpers for the yuyv to rgb converter
`timescale 1ns / 1ps

package y2r_pkg;

	// field widths
	localparam int PIX_W     = 8;
	localparam int GAIN_W    = 16;
	localparam int UNORM_W   = 16;
	localparam int CFG_IDX_W = 3;

	// centered luma and chroma widths
	localparam int LUMA_C_W   = PIX_W + 1;
	localparam int CHROMA_C_W = PIX_W;

	// product and sum widths
	localparam int LPROD_W = GAIN_W + LUMA_C_W;
	localparam int CPROD_W = GAIN_W + CHROMA_C_W;
	localparam int SUM_W   = LPROD_W + 2;

	// clamp and scale widths
	localparam int FRAC_W   = 12;
	localparam int CLAMP_W  = 20;
	localparam int SCALE_W  = CLAMP_W + 9;
	localparam int SCALED_W = SCALE_W - FRAC_W;

	// register stages from request accept to result
	localparam int PIPE_DEPTH = 4;

	// luma black level
	localparam logic [LUMA_C_W-1:0] LUMA_OFFSET = LUMA_C_W'(16);

	// 255.0 in q.12
	localparam logic signed [SUM_W-1:0] Q12_TOP = SUM_W'(255 * 4096);
	localparam logic [SCALE_W-1:0] ROUND_HALF = SCALE_W'(1 << (FRAC_W - 1));

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_LUMA         = 3'd0,
		REG_GAIN_RED_FROM_V   = 3'd1,
		REG_GAIN_GREEN_FROM_V = 3'd2,
		REG_GAIN_GREEN_FROM_U = 3'd3,
		REG_GAIN_BLUE_FROM_U  = 3'd4
	} cfg_reg_t;

	// bt.601 defaults in q4.12
	localparam logic signed [GAIN_W-1:0] GAIN_LUMA_RST         = 16'sd4768;
	localparam logic signed [GAIN_W-1:0] GAIN_RED_FROM_V_RST   = 16'sd6537;
	localparam logic signed [GAIN_W-1:0] GAIN_GREEN_FROM_V_RST = -16'sd3330;
	localparam logic signed [GAIN_W-1:0] GAIN_GREEN_FROM_U_RST = -16'sd1606;
	localparam logic signed [GAIN_W-1:0] GAIN_BLUE_FROM_U_RST  = 16'sd8263;

	// clamp a q.12 channel sum to 0..255 and map to 16-bit normalized
	function automatic logic [UNORM_W-1:0] to_unorm16(input logic signed [SUM_W-1:0] sum);
		logic [CLAMP_W-1:0]  x;
		logic [SCALE_W-1:0]  scaled;
		logic [SCALED_W-1:0] q;
		if (sum[SUM_W-1]) begin
			x = '0;
		end else if (sum > Q12_TOP) begin
			x = Q12_TOP[CLAMP_W-1:0];
		end else begin
			x = sum[CLAMP_W-1:0];
		end
		// x*257 as shift and add, then round half up
		scaled = SCALE_W'({x, 8'h00}) + SCALE_W'(x) + ROUND_HALF;
		q = scaled[SCALE_W-1:FRAC_W];
		if (q[SCALED_W-1]) begin
			return '1;
		end
		return q[UNORM_W-1:0];
	endfunction

endpackage

// ----- rtl/core/y2r_ifs.sv -----
// request channel interfaces for the yuyv to rgb converter
`timescale 1ns / 1ps

// one yuyv macropixel per request
interface y2r_in_if;
	import y2r_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] luma_first;
	logic [PIX_W-1:0] chroma_u;
	logic [PIX_W-1:0] luma_second;
	logic [PIX_W-1:0] chroma_v;
	logic             frame_last;

	modport source (
		output valid, luma_first, chroma_u, luma_second, chroma_v, frame_last,
		input  ready
	);
	modport sink (
		input  valid, luma_first, chroma_u, luma_second, chroma_v, frame_last,
		output ready
	);
endinterface

// two rgb pixels per request
interface y2r_out_if;
	import y2r_pkg::*;

	logic               valid;
	logic               ready;
	logic [UNORM_W-1:0] red_first;
	logic [UNORM_W-1:0] green_first;
	logic [UNORM_W-1:0] blue_first;
	logic [UNORM_W-1:0] red_second;
	logic [UNORM_W-1:0] green_second;
	logic [UNORM_W-1:0] blue_second;
	logic               last_out;

	modport source (
		output valid, red_first, green_first, blue_first,
		       red_second, green_second, blue_second, last_out,
		input  ready
	);
	modport sink (
		input  valid, red_first, green_first, blue_first,
		       red_second, green_second, blue_second, last_out,
		output ready
	);
endinterface

// ----- rtl/core/yuyv_to_rgb_converter.sv -----
// yuyv 4:2:2 to 16-bit normalized rgb converter, four-stage pipeline
//
//   channel     dir   handshake     payload
//   pixel_in    in    valid/ready   luma_first, chroma_u, luma_second, chroma_v, frame_last
//   pixel_out   out   valid/ready   rgb of both pixels (16 bits each), last_out
//   cfg         in    cfg_wr_en     cfg_index, cfg_wr_data (five q4.12 gains)
//
// one request per cycle while the output is not stalled; a result passes through the
// input, product, sum and clamp/scale register stages in that order.
// reset loads the bt.601 gains and empties the pipeline.
// each stage holds only while the stage after it is full and blocked, so bubbles
// close up and a request can be taken while a result waits, if any stage is empty.
`timescale 1ns / 1ps

module yuyv_to_rgb_converter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [y2r_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [y2r_pkg::GAIN_W-1:0]    cfg_wr_data,
	y2r_in_if.sink                       pixel_in,
	y2r_out_if.source                    pixel_out
);
	import y2r_pkg::*;

	// gain registers
	logic signed [GAIN_W-1:0] gain_luma_q;
	logic signed [GAIN_W-1:0] gain_red_from_v_q;
	logic signed [GAIN_W-1:0] gain_green_from_v_q;
	logic signed [GAIN_W-1:0] gain_green_from_u_q;
	logic signed [GAIN_W-1:0] gain_blue_from_u_q;

	// stage valids and stage readies
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	// stage 1: centered inputs
	logic signed [LUMA_C_W-1:0]   luma0_s1, luma1_s1;
	logic signed [CHROMA_C_W-1:0] cu_s1, cv_s1;
	logic                         last_s1;

	// stage 2: products
	logic signed [LPROD_W-1:0] lum0_s2, lum1_s2;
	logic signed [CPROD_W-1:0] rv_s2, gv_s2, gu_s2, bu_s2;
	logic                      last_s2;

	// stage 3: channel sums
	logic signed [SUM_W-1:0] r0_s3, g0_s3, b0_s3, r1_s3, g1_s3, b1_s3;
	logic                    last_s3;

	// stage 4: output register
	logic [UNORM_W-1:0] red_first_s4, green_first_s4, blue_first_s4;
	logic [UNORM_W-1:0] red_second_s4, green_second_s4, blue_second_s4;
	logic               last_s4;

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_luma_q         <= GAIN_LUMA_RST;
			gain_red_from_v_q   <= GAIN_RED_FROM_V_RST;
			gain_green_from_v_q <= GAIN_GREEN_FROM_V_RST;
			gain_green_from_u_q <= GAIN_GREEN_FROM_U_RST;
			gain_blue_from_u_q  <= GAIN_BLUE_FROM_U_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN_LUMA:         gain_luma_q         <= cfg_wr_data;
				REG_GAIN_RED_FROM_V:   gain_red_from_v_q   <= cfg_wr_data;
				REG_GAIN_GREEN_FROM_V: gain_green_from_v_q <= cfg_wr_data;
				REG_GAIN_GREEN_FROM_U: gain_green_from_u_q <= cfg_wr_data;
				REG_GAIN_BLUE_FROM_U:  gain_blue_from_u_q  <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	// a stage may load when empty or when its content moves on
	assign rdy_s4 = !valid_s4 || pixel_out.ready;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;
	assign pixel_in.ready = rdy_s1;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= pixel_in.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: register and center luma and chroma
	always_ff @(posedge clk) begin
		if (rdy_s1 && pixel_in.valid) begin
			luma0_s1 <= {1'b0, pixel_in.luma_first} - LUMA_OFFSET;
			luma1_s1 <= {1'b0, pixel_in.luma_second} - LUMA_OFFSET;
			cu_s1    <= {~pixel_in.chroma_u[PIX_W-1], pixel_in.chroma_u[PIX_W-2:0]};
			cv_s1    <= {~pixel_in.chroma_v[PIX_W-1], pixel_in.chroma_v[PIX_W-2:0]};
			last_s1  <= pixel_in.frame_last;
		end
	end

	// stage 2: gain products, chroma terms shared by both pixels
	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			lum0_s2 <= LPROD_W'(gain_luma_q) * LPROD_W'(luma0_s1);
			lum1_s2 <= LPROD_W'(gain_luma_q) * LPROD_W'(luma1_s1);
			rv_s2   <= CPROD_W'(gain_red_from_v_q) * CPROD_W'(cv_s1);
			gv_s2   <= CPROD_W'(gain_green_from_v_q) * CPROD_W'(cv_s1);
			gu_s2   <= CPROD_W'(gain_green_from_u_q) * CPROD_W'(cu_s1);
			bu_s2   <= CPROD_W'(gain_blue_from_u_q) * CPROD_W'(cu_s1);
			last_s2 <= last_s1;
		end
	end

	// stage 3: q.12 channel sums
	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			r0_s3   <= SUM_W'(lum0_s2) + SUM_W'(rv_s2);
			g0_s3   <= SUM_W'(lum0_s2) + SUM_W'(gv_s2) + SUM_W'(gu_s2);
			b0_s3   <= SUM_W'(lum0_s2) + SUM_W'(bu_s2);
			r1_s3   <= SUM_W'(lum1_s2) + SUM_W'(rv_s2);
			g1_s3   <= SUM_W'(lum1_s2) + SUM_W'(gv_s2) + SUM_W'(gu_s2);
			b1_s3   <= SUM_W'(lum1_s2) + SUM_W'(bu_s2);
			last_s3 <= last_s2;
		end
	end

	// stage 4: clamp and scale into the output register
	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			red_first_s4    <= to_unorm16(r0_s3);
			green_first_s4  <= to_unorm16(g0_s3);
			blue_first_s4   <= to_unorm16(b0_s3);
			red_second_s4   <= to_unorm16(r1_s3);
			green_second_s4 <= to_unorm16(g1_s3);
			blue_second_s4  <= to_unorm16(b1_s3);
			last_s4         <= last_s3;
		end
	end

	// result channel
	assign pixel_out.valid        = valid_s4;
	assign pixel_out.red_first    = red_first_s4;
	assign pixel_out.green_first  = green_first_s4;
	assign pixel_out.blue_first   = blue_first_s4;
	assign pixel_out.red_second   = red_second_s4;
	assign pixel_out.green_second = green_second_s4;
	assign pixel_out.blue_second  = blue_second_s4;
	assign pixel_out.last_out     = last_s4;

endmodule

// ----- rtl/core/y2r_checker.sv -----
// port-level checks for the yuyv to rgb converter and their bind
`timescale 1ns / 1ps
`include "yuyv_to_rgb_converter_macros.svh"

module y2r_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [y2r_pkg::UNORM_W-1:0] red_first,
	input logic [y2r_pkg::UNORM_W-1:0] green_first,
	input logic [y2r_pkg::UNORM_W-1:0] blue_first,
	input logic [y2r_pkg::UNORM_W-1:0] red_second,
	input logic [y2r_pkg::UNORM_W-1:0] green_second,
	input logic [y2r_pkg::UNORM_W-1:0] blue_second,
	input logic                       last_out
);
	import y2r_pkg::*;

	logic       in_acc, out_acc;
	logic [2:0] inflight_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   inflight_q <= inflight_q + 3'd1;
				2'b01:   inflight_q <= inflight_q - 3'd1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	// a stalled result stays and holds its value
	`Y2R_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`Y2R_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(red_first) && $stable(green_first) && $stable(blue_first) && $stable(red_second) && $stable(green_second) && $stable(blue_second) && $stable(last_out))

	// every result comes from an accepted request
	`Y2R_ASSERT_NOW(a_no_orphan, clk, arst_n, out_valid, inflight_q != 3'd0)

	// an empty pipeline always takes a request
	`Y2R_ASSERT_NOW(a_empty_ready, clk, arst_n, inflight_q == 3'd0, in_ready)

	// never more requests in flight than stages
	`Y2R_ASSERT_NOW(a_depth, clk, arst_n, 1'b1, inflight_q <= 3'(PIPE_DEPTH))

endmodule

bind yuyv_to_rgb_converter y2r_checker u_y2r_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pixel_in.valid),
	.in_ready     (pixel_in.ready),
	.out_valid    (pixel_out.valid),
	.out_ready    (pixel_out.ready),
	.red_first    (pixel_out.red_first),
	.green_first  (pixel_out.green_first),
	.blue_first   (pixel_out.blue_first),
	.red_second   (pixel_out.red_second),
	.green_second (pixel_out.green_second),
	.blue_second  (pixel_out.blue_second),
	.last_out     (pixel_out.last_out)
);
